FILE: hdl/gtc_pkg.sv
package gtc_pkg;

    // Item operation codes
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    // Register index carried in paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam int VC_BITS   = 7;
    localparam int TOTAL_BITS = 16;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_RD_A  = 7'b0000100,
        ST_WR_A  = 7'b0001000,
        ST_RD_B  = 7'b0010000,
        ST_WR_B  = 7'b0100000,
        ST_FLOOD = 7'b1000000
    } t_state;

    typedef struct packed {
        logic clear;       // restart marks at vertex 0
        logic pass_start;  // drop the change flag
        logic merge;       // fold the row read for the pending vertex
    } t_mark_cmd;

    typedef struct packed {
        logic changed;
        logic all_reached;
    } t_mark_stat;

endpackage

FILE: hdl/gtc_adj_ram.sv
module gtc_adj_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/gtc_mark.sv
module gtc_mark #(
    parameter int MAX_VERTICES = 64,
    parameter int CW = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gtc_pkg::t_mark_cmd              i_cmd,
    input  logic [MAX_VERTICES-1:0]         i_row,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_vtx,
    input  logic [CW-1:0]                   i_n,
    output gtc_pkg::t_mark_stat             o_stat
);

    import gtc_pkg::*;

    logic [MAX_VERTICES-1:0] r_marks;
    logic                    r_changed;
    logic [MAX_VERTICES-1:0] w_mask;
    logic [MAX_VERTICES-1:0] w_grown;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_mask[i] = (CW'(i) < i_n);
        end
    end

    assign w_grown = r_marks | (i_row & w_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks   <= '0;
            r_changed <= 1'b0;
        end else if (i_cmd.clear) begin
            r_marks   <= MAX_VERTICES'(1);
            r_changed <= 1'b0;
        end else if (i_cmd.pass_start) begin
            r_changed <= 1'b0;
        end else if (i_cmd.merge && r_marks[i_vtx]) begin
            // only a reached vertex spreads its neighbors
            r_marks <= w_grown;
            if (w_grown != r_marks) begin
                r_changed <= 1'b1;
            end
        end
    end

    assign o_stat.changed     = r_changed;
    assign o_stat.all_reached = ((r_marks & w_mask) == w_mask);

endmodule

FILE: hdl/graph_tree_connectivity_check.sv
// Undirected graph connectivity and tree test.
// Input channel: an item (operation, first/second vertex) is taken when start
// is high and busy is low. Operation add-edge sets both adjacency bits and
// counts the edge; operation query floods reachability from vertex 0.
// Result channel: o_done is high for one cycle with the item's result; the
// receiver cannot stall, so results must be taken as they come.
// An add-edge item with both endpoints in range does a read-modify-write of
// row a, then of row b, on the adjacency memory (states RD_A, WR_A, RD_B and
// WR_B); a refused edge shows its result in the cycle after acceptance.
// A query walks the memory rows once per pass (n reads, the last merge, the
// settle check), passes repeating until the marks settle or every vertex is
// reached: at most n-1 passes for n of 2 or more, one for n of one. The block
// takes one item at a time and is busy meanwhile, but not for a refused edge.
// vertex_count is written through the APB port at byte address 0. The user
// must write it only while idle; the block itself does not enforce this.
// Reset: a clearing pass zeroes every adjacency memory row, one row a cycle,
// with busy high; vertex_count returns to 1 and the edge count to 0.
module graph_tree_connectivity_check #(
    parameter int MAX_VERTICES    = 64,
    parameter int EDGE_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [5:0]  i_first_vertex,
    input  logic [5:0]  i_second_vertex,
    output logic        o_done,
    output logic        o_edge_accepted,
    output logic        o_is_connected,
    output logic        o_is_tree,
    output logic [gtc_pkg::TOTAL_BITS-1:0] o_edge_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import gtc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = (VW + 1 > VC_BITS) ? VW + 1 : VC_BITS;
    localparam int KW = (EDGE_COUNT_BITS > CW) ? EDGE_COUNT_BITS : CW;

    t_state                     r_state, n_state;
    logic [VW-1:0]              r_idx, n_idx;
    logic [VW-1:0]              r_a, n_a;
    logic [VW-1:0]              r_b, n_b;
    logic [CW-1:0]              r_v, n_v;
    logic                       r_rd_ok, n_rd_ok;
    logic [VW-1:0]              r_rd_v, n_rd_v;
    logic [EDGE_COUNT_BITS-1:0] r_count, n_count;
    logic [VC_BITS-1:0]         r_vc;
    logic                       r_done, n_done;
    logic                       r_acc, n_acc;
    logic                       r_conn, n_conn;
    logic                       r_tree, n_tree;

    logic [CW-1:0]           w_n;
    logic                    w_in_range;
    logic                    w_cfg_wr;
    logic                    w_we;
    logic [VW-1:0]           w_waddr;
    logic [VW-1:0]           w_raddr;
    logic [MAX_VERTICES-1:0] w_wdata;
    logic [MAX_VERTICES-1:0] w_rdata;
    logic [31:0]             w_total_ext;
    t_mark_cmd               w_mcmd;
    t_mark_stat              w_mstat;

    // clamp vertex_count into 1..MAX_VERTICES
    always_comb begin
        if (r_vc == '0) begin
            w_n = CW'(1);
        end else if (CW'(r_vc) > CW'(MAX_VERTICES)) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = CW'(r_vc);
        end
    end

    assign w_in_range = (CW'(i_first_vertex) < w_n) && (CW'(i_second_vertex) < w_n);
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_a     = r_a;
        n_b     = r_b;
        n_v     = r_v;
        n_rd_ok = 1'b0;
        n_rd_v  = r_rd_v;
        n_count = r_count;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_conn  = r_conn;
        n_tree  = r_tree;
        w_we    = 1'b0;
        w_waddr = r_a;
        w_wdata = '0;
        w_raddr = r_a;
        w_mcmd  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                n_idx   = r_idx + 1'b1;
                if (r_idx == VW'(MAX_VERTICES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_a = VW'(i_first_vertex);
                    n_b = VW'(i_second_vertex);
                    if (i_operation == OP_QUERY) begin
                        w_mcmd.clear = 1'b1;
                        n_v          = '0;
                        n_state      = ST_FLOOD;
                    end else if (w_in_range) begin
                        n_state = ST_RD_A;
                    end else begin
                        n_done = 1'b1;
                        n_acc  = 1'b0;
                        n_conn = 1'b0;
                        n_tree = 1'b0;
                    end
                end
            end
            ST_RD_A: begin
                w_raddr = r_a;
                n_state = ST_WR_A;
            end
            ST_WR_A: begin
                w_we    = 1'b1;
                w_waddr = r_a;
                w_wdata = w_rdata | (MAX_VERTICES'(1) << r_b);
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                w_raddr = r_b;
                n_state = ST_WR_B;
            end
            ST_WR_B: begin
                w_we    = 1'b1;
                w_waddr = r_b;
                w_wdata = w_rdata | (MAX_VERTICES'(1) << r_a);
                if (r_count != '1) begin
                    n_count = r_count + 1'b1;
                end
                n_done  = 1'b1;
                n_acc   = 1'b1;
                n_conn  = 1'b0;
                n_tree  = 1'b0;
                n_state = ST_IDLE;
            end
            ST_FLOOD: begin
                w_raddr      = r_v[VW-1:0];
                w_mcmd.merge = r_rd_ok;
                if (r_v < w_n) begin
                    n_rd_ok = 1'b1;
                    n_rd_v  = r_v[VW-1:0];
                    n_v     = r_v + 1'b1;
                end else if (!r_rd_ok) begin
                    // pass over: stop when settled or every vertex is reached
                    if (w_mstat.all_reached || !w_mstat.changed) begin
                        n_done  = 1'b1;
                        n_acc   = 1'b0;
                        n_conn  = w_mstat.all_reached;
                        n_tree  = w_mstat.all_reached &&
                                  (KW'(r_count) == KW'(w_n - 1'b1));
                        n_state = ST_IDLE;
                    end else begin
                        w_mcmd.pass_start = 1'b1;
                        n_v               = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
            r_count <= '0;
            r_vc    <= VC_BITS'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rd_ok <= n_rd_ok;
            r_count <= n_count;
            r_done  <= n_done;
            if (w_cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
                r_vc <= pwdata[VC_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_v    <= n_v;
        r_rd_v <= n_rd_v;
        r_acc  <= n_acc;
        r_conn <= n_conn;
        r_tree <= n_tree;
    end

    gtc_adj_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gtc_mark #(
        .MAX_VERTICES (MAX_VERTICES),
        .CW           (CW)
    ) u_mark (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mcmd),
        .i_row   (w_rdata),
        .i_vtx   (r_rd_v),
        .i_n     (w_n),
        .o_stat  (w_mstat)
    );

    assign w_total_ext     = 32'(r_count);
    assign busy            = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_edge_accepted = r_acc;
    assign o_is_connected  = r_conn;
    assign o_is_tree       = r_tree;
    assign o_edge_total    = w_total_ext[TOTAL_BITS-1:0];
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_VERTEX_COUNT) ? 32'(r_vc) : '0;

endmodule

FILE: hdl/gtc_checker.sv
module gtc_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_operation,
    input logic                          o_done,
    input logic                          o_edge_accepted,
    input logic                          o_is_connected,
    input logic                          o_is_tree,
    input logic [gtc_pkg::TOTAL_BITS-1:0] o_edge_total
);

    import gtc_pkg::*;

    // a query always runs through the flood before answering
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_QUERY) |=> (busy && !o_done))
        else $error("query accepted without entering the flood");

    a_tree_needs_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_is_tree && !o_is_connected))
        else $error("tree reported on a disconnected graph");

    a_edge_no_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_edge_accepted) |-> !o_is_connected)
        else $error("add-edge result carries a query flag");

    // the edge count moves only on the edge that ends an add-edge item
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_done && $past(i_rst_n)) |-> $stable(o_edge_total))
        else $error("edge total changed without a result");

endmodule

bind graph_tree_connectivity_check gtc_port_checker u_gtc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_operation     (i_operation),
    .o_done          (o_done),
    .o_edge_accepted (o_edge_accepted),
    .o_is_connected  (o_is_connected),
    .o_is_tree       (o_is_tree),
    .o_edge_total    (o_edge_total)
);
